// ----- hw/rtl/lsce_pkg.sv -----
package lsce_pkg;

  localparam int SENSOR_COUNT_DEFAULT = 16;
  localparam int INPUT_BITS = 16;

  localparam int MODE_W = 2;
  localparam int MAG_W = 5;
  localparam int WMAG_W = 9;
  localparam int WEIGHT_W = WMAG_W + 1;
  localparam int SUM_W = 14;
  localparam int NUM_W = 20;
  localparam int COUNT_W = 5;
  localparam int ERROR_W = 15;

  localparam int DIV_BITS = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_IDX_WEIGHT_MODE = 1'b0;

  localparam logic [ERROR_W-1:0] ERR_POS_LIMIT = 15'd16383;
  localparam logic [ERROR_W-1:0] ERR_NEG_LIMIT = 15'd16384;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_EXP    = 2'd2
  } weight_mode_t;

  localparam logic [WMAG_W-1:0] EXP_TABLE [8] = '{
    9'd1, 9'd2, 9'd4, 9'd8, 9'd16, 9'd32, 9'd48, 9'd64
  };

  typedef struct packed {
    logic               neg;
    logic [NUM_W-1:0]   num;
    logic [COUNT_W-1:0] count;
  } quot_req_t;

  typedef struct packed {
    logic               neg;
    logic [NUM_W-1:0]   quo;
    logic [COUNT_W-1:0] count;
  } quot_rsp_t;

  function automatic logic [WMAG_W-1:0] weight_mag(input logic [MODE_W-1:0] mode,
                                                    input logic [MAG_W-1:0] mag);
    logic [2*MAG_W-1:0] sq;
    logic [MAG_W-1:0] tmag;
    logic [WMAG_W-1:0] res;
    sq = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};
    tmag = (mag > 5'd8) ? 5'd8 : mag;
    case (weight_mode_t'(mode))
      MODE_SQUARE: res = sq[WMAG_W-1:0];
      MODE_EXP:    res = EXP_TABLE[3'(tmag - 5'd1)];
      default:     res = WMAG_W'(mag);
    endcase
    return res;
  endfunction

endpackage

// ----- hw/rtl/lsce_front.sv -----
module lsce_front #(
  parameter int SENSOR_COUNT = lsce_pkg::SENSOR_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lsce_pkg::MODE_W-1:0]     weight_mode,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [lsce_pkg::INPUT_BITS-1:0] sensor_bits,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output lsce_pkg::quot_req_t           dn_req
);
  import lsce_pkg::*;

  localparam int HALF = SENSOR_COUNT / 2;
  localparam int USED = (SENSOR_COUNT < INPUT_BITS) ? SENSOR_COUNT : INPUT_BITS;
  localparam int STAGES = 4;
  localparam int PARTS = 4;
  localparam int PART_LEN = INPUT_BITS / PARTS;
  localparam int PCNT_W = $clog2(PART_LEN + 1);

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] load;

  logic signed [WEIGHT_W-1:0] weight [INPUT_BITS];
  logic signed [WEIGHT_W-1:0] weight_next [INPUT_BITS];
  logic [INPUT_BITS-1:0]      lit;
  logic [INPUT_BITS-1:0]      lit_next;

  logic signed [SUM_W-1:0] psum [PARTS];
  logic signed [SUM_W-1:0] psum_next [PARTS];
  logic [PCNT_W-1:0]       pcnt [PARTS];
  logic [PCNT_W-1:0]       pcnt_next [PARTS];

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [COUNT_W-1:0]      count;
  logic [COUNT_W-1:0]      count_next;

  logic [SUM_W-1:0]        absval;
  quot_req_t               req;
  quot_req_t               req_next;

  always_comb begin
    load[STAGES-1] = !valid[STAGES-1] || dn_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  assign up_ready = load[0];
  assign dn_valid = valid[STAGES-1];
  assign dn_req = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= up_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  always_comb begin
    logic [WMAG_W-1:0] wm;
    for (int k = 0; k < INPUT_BITS; k++) begin
      wm = weight_mag(weight_mode, MAG_W'((k < HALF) ? (HALF - k) : (k - HALF + 1)));
      lit_next[k] = sensor_bits[k] && (k < USED);
      if (!lit_next[k]) begin
        weight_next[k] = '0;
      end else if (k < HALF) begin
        weight_next[k] = -$signed({1'b0, wm});
      end else begin
        weight_next[k] = $signed({1'b0, wm});
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PARTS; p++) begin
      psum_next[p] = '0;
      pcnt_next[p] = '0;
      for (int j = 0; j < PART_LEN; j++) begin
        psum_next[p] = psum_next[p] + SUM_W'(weight[p*PART_LEN+j]);
        pcnt_next[p] = pcnt_next[p] + PCNT_W'(lit[p*PART_LEN+j]);
      end
    end
  end

  always_comb begin
    sum_next = '0;
    count_next = '0;
    for (int p = 0; p < PARTS; p++) begin
      sum_next = sum_next + psum[p];
      count_next = count_next + COUNT_W'(pcnt[p]);
    end
  end

  always_comb begin
    absval = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    req_next.neg = sum[SUM_W-1];
    req_next.num = (NUM_W'(absval) << 7) + (NUM_W'(absval) << 6) + (NUM_W'(absval) << 3);
    req_next.count = count;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      weight <= weight_next;
      lit <= lit_next;
    end
    if (load[1]) begin
      psum <= psum_next;
      pcnt <= pcnt_next;
    end
    if (load[2]) begin
      sum <= sum_next;
      count <= count_next;
    end
    if (load[3]) begin
      req <= req_next;
    end
  end

endmodule

// ----- hw/rtl/lsce_div.sv -----
module lsce_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  lsce_pkg::quot_req_t up_req,
  output logic                dn_valid,
  input  logic                dn_ready,
  output lsce_pkg::quot_rsp_t dn_rsp
);
  import lsce_pkg::*;

  localparam int PAD_W = DIV_STAGES * DIV_BITS;

  logic [DIV_STAGES-1:0] valid;
  logic [DIV_STAGES-1:0] load;

  logic               neg [DIV_STAGES];
  logic [PAD_W-1:0]   num [DIV_STAGES];
  logic [PAD_W-1:0]   quo [DIV_STAGES];
  logic [COUNT_W-1:0] rem [DIV_STAGES];
  logic [COUNT_W-1:0] den [DIV_STAGES];

  logic               neg_next [DIV_STAGES];
  logic [PAD_W-1:0]   num_next [DIV_STAGES];
  logic [PAD_W-1:0]   quo_next [DIV_STAGES];
  logic [COUNT_W-1:0] rem_next [DIV_STAGES];
  logic [COUNT_W-1:0] den_next [DIV_STAGES];

  always_comb begin
    load[DIV_STAGES-1] = !valid[DIV_STAGES-1] || dn_ready;
    for (int i = DIV_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  assign up_ready = load[0];
  assign dn_valid = valid[DIV_STAGES-1];
  assign dn_rsp.neg = neg[DIV_STAGES-1];
  assign dn_rsp.quo = quo[DIV_STAGES-1][NUM_W-1:0];
  assign dn_rsp.count = den[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= up_valid;
      end
      for (int i = 1; i < DIV_STAGES; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  always_comb begin
    logic [PAD_W-1:0]   n;
    logic [PAD_W-1:0]   q;
    logic [COUNT_W-1:0] r;
    logic [COUNT_W-1:0] d;
    logic [COUNT_W:0]   re;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        n = PAD_W'(up_req.num);
        q = '0;
        r = '0;
        d = up_req.count;
        neg_next[s] = up_req.neg;
      end else begin
        n = num[s-1];
        q = quo[s-1];
        r = rem[s-1];
        d = den[s-1];
        neg_next[s] = neg[s-1];
      end
      for (int b = 0; b < DIV_BITS; b++) begin
        re = {r, n[PAD_W-1]};
        n = {n[PAD_W-2:0], 1'b0};
        if (re >= {1'b0, d}) begin
          re = re - {1'b0, d};
          q = {q[PAD_W-2:0], 1'b1};
        end else begin
          q = {q[PAD_W-2:0], 1'b0};
        end
        r = re[COUNT_W-1:0];
      end
      num_next[s] = n;
      quo_next[s] = q;
      rem_next[s] = r;
      den_next[s] = d;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (load[s]) begin
        neg[s] <= neg_next[s];
        num[s] <= num_next[s];
        quo[s] <= quo_next[s];
        rem[s] <= rem_next[s];
        den[s] <= den_next[s];
      end
    end
  end

endmodule

// ----- hw/rtl/line_sensor_centroid_error.sv -----
// Line sensor centroid error: each beat on the sensor channel is one snapshot of the sensor
// bar, and each beat on the result channel is the weighted centroid of the lit sensors times
// 12.5 in Q4 (error_q4, truncated toward zero, saturated to 15 bits, 0 when nothing is lit)
// with the lit count. The block takes one snapshot per clock when the result side is not
// stalled and returns results in order through weighting and summing stages, a restoring
// divider that resolves four quotient bits per stage, and one output register. The weight
// mode register at byte address 0 selects linear (0 or 3), signed squared (1) or
// exponential table (2) weights and must be written only while no snapshot is in flight.
module line_sensor_centroid_error #(
  parameter int SENSOR_COUNT = lsce_pkg::SENSOR_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sensor_valid,
  output logic                                 sensor_ready,
  input  logic [lsce_pkg::INPUT_BITS-1:0]        sensor_bits,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [lsce_pkg::ERROR_W-1:0]    error_q4,
  output logic [lsce_pkg::COUNT_W-1:0]           lit_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lsce_pkg::ADDR_W-1:0]            paddr,
  input  logic [lsce_pkg::DATA_W-1:0]            pwdata,
  output logic [lsce_pkg::DATA_W-1:0]            prdata,
  output logic                                 pready
);
  import lsce_pkg::*;

  logic [MODE_W-1:0] weight_mode;
  logic              reg_sel;

  logic      front_valid;
  logic      front_ready;
  quot_req_t front_req;
  logic      div_valid;
  logic      div_ready;
  quot_rsp_t div_rsp;

  logic [ERROR_W-1:0] mag_next;
  logic [ERROR_W-1:0] error_next;

  assign pready = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_IDX_WEIGHT_MODE);
  assign prdata = reg_sel ? DATA_W'(weight_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= MODE_LINEAR;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      weight_mode <= pwdata[MODE_W-1:0];
    end
  end

  lsce_front #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .weight_mode(weight_mode),
    .up_valid   (sensor_valid),
    .up_ready   (sensor_ready),
    .sensor_bits(sensor_bits),
    .dn_valid   (front_valid),
    .dn_ready   (front_ready),
    .dn_req     (front_req)
  );

  lsce_div u_div (
    .clk     (clk),
    .rst     (rst),
    .up_valid(front_valid),
    .up_ready(front_ready),
    .up_req  (front_req),
    .dn_valid(div_valid),
    .dn_ready(div_ready),
    .dn_rsp  (div_rsp)
  );

  assign div_ready = !result_valid || result_ready;

  always_comb begin
    if (div_rsp.neg) begin
      mag_next = (div_rsp.quo > NUM_W'(ERR_NEG_LIMIT)) ? ERR_NEG_LIMIT
                                                       : div_rsp.quo[ERROR_W-1:0];
      error_next = -mag_next;
    end else begin
      mag_next = (div_rsp.quo > NUM_W'(ERR_POS_LIMIT)) ? ERR_POS_LIMIT
                                                       : div_rsp.quo[ERROR_W-1:0];
      error_next = mag_next;
    end
    if (div_rsp.count == '0) begin
      error_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (div_ready) begin
      result_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      error_q4 <= $signed(error_next);
      lit_count <= div_rsp.count;
    end
  end

endmodule

// ----- hw/rtl/lsce_checker.sv -----
module lsce_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [lsce_pkg::ERROR_W-1:0] error_q4,
  input logic [lsce_pkg::COUNT_W-1:0]        lit_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(error_q4) && $stable(lit_count))
    else $error("Stalled result beat changed.");

  a_dark_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && lit_count == 5'd0 |-> error_q4 == 15'sd0)
    else $error("Nonzero error with no lit sensor.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> lit_count <= 5'd16)
    else $error("Lit count exceeds the input width.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("Result beat present right after reset.");

endmodule

bind line_sensor_centroid_error lsce_checker u_lsce_checker (.*);
